[rtl/successor_position_search_core_assert.svh]
`ifndef SUCCESSOR_POSITION_SEARCH_CORE_ASSERT_SVH
`define SUCCESSOR_POSITION_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPSC_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("spsc assertion failed");

// next-cycle implication, checked out of reset
`define SPSC_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("spsc assertion failed");

`endif

[rtl/spsc_pkg.sv]
package spsc_pkg;

    localparam int OPCODE_W = 2;
    localparam int RANK_W   = 16;
    localparam int POS_W    = 10;

    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic step;
        logic finish;
    } spsc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic out_busy;
    } spsc_sts_t;

endpackage

[rtl/spsc_ctrl.sv]
`include "successor_position_search_core_assert.svh"

module spsc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spsc_pkg::OPCODE_W-1:0] opcode,
    input  logic                          out_ready,
    input  spsc_pkg::spsc_sts_t           sts,
    output spsc_pkg::spsc_cmd_t           cmd
);
    import spsc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = sts.count_zero ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                            // unused code, word is dropped
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read word is compared in this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SPSC_ASSERT_NOW(a_scan_nonempty, clk, rst_n, state_reg == ST_SCAN, !sts.count_zero)
    `SPSC_ASSERT_NOW(a_finish_slot_free, clk, rst_n, cmd.finish, !sts.out_busy || out_ready)
    `SPSC_ASSERT_NEXT(a_query_leaves_idle, clk, rst_n, accept && opcode == OP_QUERY, !in_ready)

endmodule

[rtl/spsc_dpath.sv]
module spsc_dpath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [spsc_pkg::RANK_W-1:0] rank,
    input  spsc_pkg::spsc_cmd_t         cmd,
    output spsc_pkg::spsc_sts_t         sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [spsc_pkg::POS_W-1:0]  target_position,
    output logic [spsc_pkg::POS_W-1:0]  lowest_position,
    output logic                        found_greater,
    output logic                        table_empty
);
    import spsc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (AW > POS_W) ? AW : POS_W;

    logic [RANK_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]     count_reg;
    logic [POS_W-1:0]  last_target_reg;
    logic [RANK_W-1:0] query_rank_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [RANK_W-1:0] rdata_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_pos_reg;
    logic [RANK_W-1:0] low_val_reg;
    logic [AW-1:0]     low_pos_reg;
    logic [RANK_W-1:0] best_val_reg;
    logic [AW-1:0]     best_pos_reg;
    logic              found_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  target_position_reg;
    logic [POS_W-1:0]  lowest_position_reg;
    logic              found_greater_reg;
    logic              table_empty_reg;

    logic              full;
    logic              take_low;
    logic              take_best;
    logic [XW-1:0]     best_pos_ext;
    logic [XW-1:0]     low_pos_ext;
    logic [POS_W-1:0]  result_target;

    assign full = (count_reg >= CW'(TABLE_DEPTH));

    assign sts.count_zero = (count_reg == '0);
    assign sts.last_issue = ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
    assign sts.out_busy   = out_valid_reg;

    assign take_low  = cmp_valid_reg && ((cmp_pos_reg == '0) || (rdata_reg < low_val_reg));
    assign take_best = cmp_valid_reg && (rdata_reg > query_rank_reg)
                       && (!found_reg || (rdata_reg < best_val_reg));

    assign best_pos_ext  = XW'(best_pos_reg);
    assign low_pos_ext   = XW'(low_pos_reg);
    assign result_target = found_reg ? best_pos_ext[POS_W-1:0] : low_pos_ext[POS_W-1:0];

    // rank storage, one write port for appends, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            mem[count_reg[AW-1:0]] <= rank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            last_target_reg <= '0;
            rd_idx_reg      <= '0;
            cmp_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg       <= '0;
                last_target_reg <= '0;
            end
            else if (cmd.append && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end

            if (cmd.start)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    rd_idx_reg <= rd_idx_reg + AW'(1);
                end
                if (take_best)
                begin
                    found_reg <= 1'b1;
                end
            end

            cmp_valid_reg <= cmd.step;

            if (cmd.finish && !sts.count_zero)
            begin
                last_target_reg <= result_target;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath and result words, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_rank_reg <= rank;
        end
        if (cmd.step)
        begin
            cmp_pos_reg <= rd_idx_reg;
        end
        if (take_low)
        begin
            low_val_reg <= rdata_reg;
            low_pos_reg <= cmp_pos_reg;
        end
        if (take_best)
        begin
            best_val_reg <= rdata_reg;
            best_pos_reg <= cmp_pos_reg;
        end
        if (cmd.finish)
        begin
            if (sts.count_zero)
            begin
                target_position_reg <= last_target_reg;
                lowest_position_reg <= '0;
                found_greater_reg   <= 1'b0;
                table_empty_reg     <= 1'b1;
            end
            else
            begin
                target_position_reg <= result_target;
                lowest_position_reg <= low_pos_ext[POS_W-1:0];
                found_greater_reg   <= found_reg;
                table_empty_reg     <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_position = target_position_reg;
    assign lowest_position = lowest_position_reg;
    assign found_greater   = found_greater_reg;
    assign table_empty     = table_empty_reg;

endmodule

[rtl/successor_position_search_core.sv]
// timing: clear and append take effect at accept; a query scans its N entries in SCAN,
// compares the last one in DRAIN, then registers its result in FINISH (straight from
// IDLE on an empty table); clear/append one word per cycle, and no new command until
// the result is registered; the single rank memory read port scans one entry per cycle
// reset: rst_n async low clears entry count, last target, fsm and output valid;
// rank memory contents stay undefined until appended
module successor_position_search_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spsc_pkg::OPCODE_W-1:0] opcode,
    input  logic [spsc_pkg::RANK_W-1:0]   rank,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [spsc_pkg::POS_W-1:0]    target_position,
    output logic [spsc_pkg::POS_W-1:0]    lowest_position,
    output logic                          found_greater,
    output logic                          table_empty
);
    import spsc_pkg::*;

    spsc_cmd_t cmd;
    spsc_sts_t sts;

    spsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spsc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .rank            (rank),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .target_position (target_position),
        .lowest_position (lowest_position),
        .found_greater   (found_greater),
        .table_empty     (table_empty)
    );

endmodule
